FILE: sv/tams_pkg.sv
`default_nettype none

package tams_pkg;

    localparam int POS_BITS = 32;
    localparam int IN_POS_W = 32;
    localparam int DIFF_W   = POS_BITS + 1;
    localparam int SPEED_W  = 8;
    localparam int TOL_W    = 16;
    localparam int MIN_W    = 8;
    localparam int CFG_W    = 16;
    localparam int PROD_W   = DIFF_W + SPEED_W;
    localparam int CMP_W    = (DIFF_W > TOL_W) ? DIFF_W : TOL_W;
    localparam int DIV_STEPS = SPEED_W;

    typedef enum logic {
        CFG_TOL = 1'b0,
        CFG_MIN = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        SC_NONE = 2'd0,
        SC_X    = 2'd1,
        SC_Y    = 2'd2
    } t_scale;

    typedef struct packed {
        logic signed [IN_POS_W-1:0] goal_x;
        logic signed [IN_POS_W-1:0] goal_y;
        logic signed [IN_POS_W-1:0] current_x;
        logic signed [IN_POS_W-1:0] current_y;
        logic [SPEED_W-1:0]         base_speed;
    } t_in;

    typedef struct packed {
        logic               arrived;
        logic               x_forward;
        logic [SPEED_W-1:0] x_speed;
        logic               y_forward;
        logic [SPEED_W-1:0] y_speed;
    } t_out;

    // signed differences
    typedef struct packed {
        logic [DIFF_W-1:0]  dx;
        logic [DIFF_W-1:0]  dy;
        logic [SPEED_W-1:0] base;
    } t_s1;

    // magnitudes and flags
    typedef struct packed {
        logic [DIFF_W-1:0]  ax;
        logic [DIFF_W-1:0]  ay;
        logic               en_x;
        logic               en_y;
        logic               x_fwd;
        logic               y_fwd;
        logic [SPEED_W-1:0] base;
    } t_s2;

    // divider pipeline item
    typedef struct packed {
        logic               arrived;
        logic               en_x;
        logic               en_y;
        logic               x_fwd;
        logic               y_fwd;
        t_scale             scale;
        logic [SPEED_W-1:0] base;
        logic [PROD_W-1:0]  rem;
        logic [PROD_W-1:0]  dvs;
        logic [SPEED_W-1:0] quo;
    } t_div;

    function automatic logic [DIFF_W-1:0] pos_ext(input logic [IN_POS_W-1:0] raw);
        return {raw[POS_BITS-1], raw[POS_BITS-1:0]};
    endfunction

endpackage

`default_nettype wire

FILE: sv/two_axis_move_speed_step.sv
// two-axis move speed step
// input channel: i_valid / o_stall with i_data (targets, current positions,
// base speed); a beat is taken when i_valid is high and o_stall is low
// output channel: o_valid / i_stall with o_data (arrived, directions, speeds);
// a beat leaves when o_valid is high and i_stall is low
// config: i_cfg_we with i_cfg_idx (0 tolerance, 1 minimum speed) and
// i_cfg_data, written at the clock edge; the user must write it only while
// the pipe is empty, which the block itself does not enforce
// pipeline: 3 front stages, 8 divider stages one quotient bit each, and
// 1 output register; throughput: one beat per cycle while i_stall is low,
// set by the fully pipelined divider; stall: each stage holds only while it
// is full and the stage after it holds, so bubbles close up and o_stall rises
// only when all 12 stages are full; reset: synchronous, active low; pipe
// emptied, tolerance and minimum speed return to 5
`default_nettype none

module two_axis_move_speed_step (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  tams_pkg::t_in               i_data,
    output logic                        o_valid,
    input  logic                        i_stall,
    output tams_pkg::t_out              o_data,
    input  logic                        i_cfg_we,
    input  tams_pkg::t_cfg_idx          i_cfg_idx,
    input  logic [tams_pkg::CFG_W-1:0]  i_cfg_data
);
    import tams_pkg::*;

    logic [TOL_W-1:0] r_tol, n_tol;
    logic [MIN_W-1:0] r_min, n_min;

    logic r_s1_valid, r_s2_valid, r_s3_valid, r_out_valid;
    t_s1  r_s1, n_s1;
    t_s2  r_s2, n_s2;
    t_div r_s3, n_s3;
    t_out r_out, n_out;

    logic adv_s1, adv_s2, adv_s3, adv_out;
    logic [DIV_STEPS-1:0] adv_d;
    logic [DIV_STEPS-1:0] dv;
    t_div                 ditem [DIV_STEPS];

    // config
    always_comb begin
        n_tol = r_tol;
        n_min = r_min;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TOL: n_tol = i_cfg_data[TOL_W-1:0];
                CFG_MIN: n_min = i_cfg_data[MIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_W'(5);
            r_min <= MIN_W'(5);
        end else begin
            r_tol <= n_tol;
            r_min <= n_min;
        end
    end

    // advance chain
    assign adv_out = !r_out_valid || !i_stall;
    assign adv_d[DIV_STEPS-1] = !dv[DIV_STEPS-1] || adv_out;
    for (genvar j = 0; j < DIV_STEPS - 1; j++) begin : g_adv
        assign adv_d[j] = !dv[j] || adv_d[j+1];
    end
    assign adv_s3 = !r_s3_valid || adv_d[0];
    assign adv_s2 = !r_s2_valid || adv_s3;
    assign adv_s1 = !r_s1_valid || adv_s2;
    assign o_stall = !adv_s1;

    // stage 1: differences
    always_comb begin
        n_s1.dx   = pos_ext(i_data.goal_x) - pos_ext(i_data.current_x);
        n_s1.dy   = pos_ext(i_data.goal_y) - pos_ext(i_data.current_y);
        n_s1.base = i_data.base_speed;
    end

    // stage 2: magnitudes, tolerance test, directions
    always_comb begin
        n_s2.ax    = r_s1.dx[DIFF_W-1] ? (DIFF_W'(0) - r_s1.dx) : r_s1.dx;
        n_s2.ay    = r_s1.dy[DIFF_W-1] ? (DIFF_W'(0) - r_s1.dy) : r_s1.dy;
        n_s2.en_x  = CMP_W'(n_s2.ax) > CMP_W'(r_tol);
        n_s2.en_y  = CMP_W'(n_s2.ay) > CMP_W'(r_tol);
        n_s2.x_fwd = !r_s1.dx[DIFF_W-1] && (r_s1.dx != '0);
        n_s2.y_fwd = !r_s1.dy[DIFF_W-1] && (r_s1.dy != '0);
        n_s2.base  = r_s1.base;
    end

    // stage 3: pick the short axis, form the dividend
    always_comb begin
        logic [DIFF_W-1:0] short_d;
        logic [DIFF_W-1:0] long_d;
        short_d      = r_s2.ay;
        long_d       = r_s2.ax;
        n_s3.scale   = SC_NONE;
        if (r_s2.en_x && r_s2.en_y) begin
            if (r_s2.ax > r_s2.ay) begin
                n_s3.scale = SC_Y;
            end else if (r_s2.ay > r_s2.ax) begin
                n_s3.scale = SC_X;
                short_d    = r_s2.ax;
                long_d     = r_s2.ay;
            end
        end
        n_s3.arrived = !r_s2.en_x && !r_s2.en_y;
        n_s3.en_x    = r_s2.en_x;
        n_s3.en_y    = r_s2.en_y;
        n_s3.x_fwd   = r_s2.x_fwd;
        n_s3.y_fwd   = r_s2.y_fwd;
        n_s3.base    = r_s2.base;
        n_s3.rem     = PROD_W'(r_s2.base) * PROD_W'(short_d);
        n_s3.dvs     = PROD_W'(long_d) << (SPEED_W - 1);
        n_s3.quo     = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            if (adv_s1) begin
                r_s1_valid <= i_valid;
            end
            if (adv_s2) begin
                r_s2_valid <= r_s1_valid;
            end
            if (adv_s3) begin
                r_s3_valid <= r_s2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_s1) begin
            r_s1 <= n_s1;
        end
        if (adv_s2) begin
            r_s2 <= n_s2;
        end
        if (adv_s3) begin
            r_s3 <= n_s3;
        end
    end

    // divider, one quotient bit per stage
    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
        if (j == 0) begin : g_first
            tams_div_step u_step (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_adv   (adv_d[j]),
                .i_valid (r_s3_valid),
                .i_item  (r_s3),
                .o_valid (dv[j]),
                .o_item  (ditem[j])
            );
        end else begin : g_next
            tams_div_step u_step (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_adv   (adv_d[j]),
                .i_valid (dv[j-1]),
                .i_item  (ditem[j-1]),
                .o_valid (dv[j]),
                .o_item  (ditem[j])
            );
        end
    end

    // output stage: speed select and minimum speed
    always_comb begin
        t_div              d;
        logic [SPEED_W-1:0] sx;
        logic [SPEED_W-1:0] sy;
        d  = ditem[DIV_STEPS-1];
        sx = '0;
        sy = '0;
        if (d.en_x) begin
            sx = (d.scale == SC_X) ? d.quo : d.base;
        end
        if (d.en_y) begin
            sy = (d.scale == SC_Y) ? d.quo : d.base;
        end
        if (sx < r_min) begin
            sx = '0;
        end
        if (sy < r_min) begin
            sy = '0;
        end
        if (d.arrived) begin
            n_out.arrived   = 1'b1;
            n_out.x_forward = 1'b0;
            n_out.x_speed   = '0;
            n_out.y_forward = 1'b0;
            n_out.y_speed   = '0;
        end else begin
            n_out.arrived   = 1'b0;
            n_out.x_forward = d.x_fwd;
            n_out.x_speed   = sx;
            n_out.y_forward = d.y_fwd;
            n_out.y_speed   = sy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv_out) begin
            r_out_valid <= dv[DIV_STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_out) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

`default_nettype wire

FILE: sv/tams_div_step.sv
`default_nettype none

module tams_div_step (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_adv,
    input  logic          i_valid,
    input  tams_pkg::t_div i_item,
    output logic          o_valid,
    output tams_pkg::t_div o_item
);
    import tams_pkg::*;

    logic              r_valid;
    t_div              r_item;
    t_div              n_item;
    logic              ge;
    logic [PROD_W-1:0] diff;

    // one restoring step: compare against divisor scaled to the top quotient bit
    always_comb begin
        ge     = (i_item.rem >= i_item.dvs);
        diff   = ge ? (i_item.rem - i_item.dvs) : i_item.rem;
        n_item = i_item;
        n_item.rem = {diff[PROD_W-2:0], 1'b0};
        n_item.quo = {i_item.quo[SPEED_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire
